[design/lswc_pkg.sv]
package lswc_pkg;

    localparam int COORD_WIDTH_DEF    = 16;
    localparam int MAX_CLIP_STEPS_DEF = 4;
    localparam int QUEUE_DEPTH        = 2;
    localparam int CALC_WIDTH         = 32;

    localparam logic [3:0] CODE_LEFT  = 4'd1;
    localparam logic [3:0] CODE_RIGHT = 4'd2;
    localparam logic [3:0] CODE_BELOW = 4'd4;
    localparam logic [3:0] CODE_ABOVE = 4'd8;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_RIGHT  = 2'd1,
        REG_BOTTOM = 2'd2,
        REG_TOP    = 2'd3
    } t_reg_index;

    // Region code of a point; all values are sign-extended to CALC_WIDTH.
    function automatic logic [3:0] f_outcode(
        input logic signed [CALC_WIDTH-1:0] x,
        input logic signed [CALC_WIDTH-1:0] y,
        input logic signed [CALC_WIDTH-1:0] left,
        input logic signed [CALC_WIDTH-1:0] right,
        input logic signed [CALC_WIDTH-1:0] bottom,
        input logic signed [CALC_WIDTH-1:0] top
    );
        logic [3:0] code;
        code = 4'd0;
        if (x < left) begin
            code = code | CODE_LEFT;
        end else if (x > right) begin
            code = code | CODE_RIGHT;
        end
        if (y < bottom) begin
            code = code | CODE_BELOW;
        end else if (y > top) begin
            code = code | CODE_ABOVE;
        end
        return code;
    endfunction

endpackage

[design/lswc_fifo.sv]
module lswc_fifo #(
    parameter int WIDTH = 72,
    parameter int DEPTH = lswc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[design/lswc_front.sv]
module lswc_front #(
    parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_left,
    input  logic signed [COORD_WIDTH-1:0] i_right,
    input  logic signed [COORD_WIDTH-1:0] i_bottom,
    input  logic signed [COORD_WIDTH-1:0] i_top,
    output logic                          o_q_push,
    output logic [4*COORD_WIDTH+7:0]      o_q_data,
    input  logic                          i_q_full
);
    localparam int CW = lswc_pkg::CALC_WIDTH;

    logic                     r_valid;
    logic [4*COORD_WIDTH+7:0] r_item;
    logic [3:0]               c_start;
    logic [3:0]               c_end;
    logic                     accept;

    // Classify both endpoints as the item comes in.
    always_comb begin
        c_start = lswc_pkg::f_outcode(CW'(i_start_x), CW'(i_start_y), CW'(i_left),
                                      CW'(i_right), CW'(i_bottom), CW'(i_top));
        c_end   = lswc_pkg::f_outcode(CW'(i_end_x), CW'(i_end_y), CW'(i_left),
                                      CW'(i_right), CW'(i_bottom), CW'(i_top));
    end

    assign o_q_push = r_valid && !i_q_full;
    assign o_full   = r_valid && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_data = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= {i_start_x, i_start_y, i_end_x, i_end_y, c_start, c_end};
        end
    end

endmodule

[design/lswc_back.sv]
module lswc_back #(
    parameter int COORD_WIDTH    = lswc_pkg::COORD_WIDTH_DEF,
    parameter int MAX_CLIP_STEPS = lswc_pkg::MAX_CLIP_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [4*COORD_WIDTH+7:0]      i_q_data,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    input  logic signed [COORD_WIDTH-1:0] i_left,
    input  logic signed [COORD_WIDTH-1:0] i_right,
    input  logic signed [COORD_WIDTH-1:0] i_bottom,
    input  logic signed [COORD_WIDTH-1:0] i_top,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_visible,
    output logic signed [COORD_WIDTH-1:0] o_x1,
    output logic signed [COORD_WIDTH-1:0] o_y1,
    output logic signed [COORD_WIDTH-1:0] o_x2,
    output logic signed [COORD_WIDTH-1:0] o_y2
);
    localparam int W  = COORD_WIDTH;
    localparam int CW = lswc_pkg::CALC_WIDTH;
    localparam int SW = $clog2(MAX_CLIP_STEPS + 1);
    localparam int NW = $clog2(2 * W);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_MUL, S_DIV, S_UPD, S_DONE
    } t_state;

    t_state                r_state;
    logic signed [W-1:0]   r_x1, r_y1, r_x2, r_y2;
    logic [3:0]            r_c1, r_c2;
    logic                  r_vis;
    logic [SW-1:0]         r_step;
    logic [W-1:0]          r_amag, r_bmag, r_dmag;
    logic                  r_neg, r_zero, r_horiz, r_sel;
    logic signed [W-1:0]   r_base, r_bnd, r_keep;
    logic [2*W-1:0]        r_dvd;
    logic [W-1:0]          r_rem;
    logic [NW-1:0]         r_cnt;

    logic                  sel;
    logic [3:0]            code;
    logic                  horiz;
    logic signed [W-1:0]   bnd, base, keep;
    logic signed [W:0]     da, db, dd;
    logic [W:0]            trial;
    logic                  ge;
    logic [W-1:0]          quot;
    logic signed [W-1:0]   newv;
    logic signed [W-1:0]   ux, uy;
    logic [3:0]            ucode;

    function automatic logic signed [W:0] f_diff(input logic signed [W-1:0] p,
                                                 input logic signed [W-1:0] q);
        return {p[W-1], p} - {q[W-1], q};
    endfunction

    function automatic logic [W-1:0] f_mag(input logic signed [W:0] v);
        logic [W:0] m;
        m = v[W] ? -v : v;
        return m[W-1:0];
    endfunction

    // Pick the outside endpoint and the boundary it crosses.
    always_comb begin
        sel   = (r_c1 != 4'd0);
        code  = sel ? r_c1 : r_c2;
        horiz = ((code & (lswc_pkg::CODE_LEFT | lswc_pkg::CODE_RIGHT)) != 4'd0);
        if (horiz) begin
            bnd  = ((code & lswc_pkg::CODE_LEFT) != 4'd0) ? i_left : i_right;
            da   = f_diff(r_y2, r_y1);
            db   = f_diff(bnd, r_x1);
            dd   = f_diff(r_x2, r_x1);
            base = r_y1;
            keep = sel ? r_y1 : r_y2;
        end else begin
            bnd  = ((code & lswc_pkg::CODE_BELOW) != 4'd0) ? i_bottom : i_top;
            da   = f_diff(r_x2, r_x1);
            db   = f_diff(bnd, r_y1);
            dd   = f_diff(r_y2, r_y1);
            base = r_x1;
            keep = sel ? r_x1 : r_x2;
        end
    end

    // One restoring division step per cycle.
    assign trial = {r_rem, r_dvd[2*W-1]};
    assign ge    = (trial >= {1'b0, r_dmag});

    always_comb begin
        quot = r_dvd[W-1:0];
        newv = r_zero ? r_keep : (r_base + (r_neg ? -quot : quot));
        ux   = r_sel ? r_x1 : r_x2;
        uy   = r_sel ? r_y1 : r_y2;
        if (r_horiz) begin
            ux = r_bnd;
            uy = newv;
        end else begin
            ux = newv;
            uy = r_bnd;
        end
        ucode = lswc_pkg::f_outcode(CW'(ux), CW'(uy), CW'(i_left), CW'(i_right),
                                    CW'(i_bottom), CW'(i_top));
    end

    assign o_q_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty   = (r_state != S_DONE);
    assign o_visible = r_vis;
    assign o_x1      = r_x1;
    assign o_y1      = r_y1;
    assign o_x2      = r_x2;
    assign o_y2      = r_y2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        {r_x1, r_y1, r_x2, r_y2, r_c1, r_c2} <= i_q_data;
                        r_step  <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_c1 == 4'd0 && r_c2 == 4'd0) begin
                        r_vis   <= 1'b1;
                        r_state <= S_DONE;
                    end else if ((r_c1 & r_c2) != 4'd0
                                 || r_step == SW'(MAX_CLIP_STEPS)) begin
                        r_vis   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_amag  <= f_mag(da);
                        r_bmag  <= f_mag(db);
                        r_dmag  <= f_mag(dd);
                        r_neg   <= da[W] ^ db[W] ^ dd[W];
                        r_zero  <= (dd == '0);
                        r_horiz <= horiz;
                        r_sel   <= sel;
                        r_base  <= base;
                        r_bnd   <= bnd;
                        r_keep  <= keep;
                        r_state <= (dd == '0) ? S_UPD : S_MUL;
                    end
                end
                S_MUL: begin
                    r_dvd   <= r_amag * r_bmag;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem   <= ge ? W'(trial - {1'b0, r_dmag}) : trial[W-1:0];
                    r_dvd   <= {r_dvd[2*W-2:0], ge};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == NW'(2 * W - 1)) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_sel) begin
                        r_x1 <= ux;
                        r_y1 <= uy;
                        r_c1 <= ucode;
                    end else begin
                        r_x2 <= ux;
                        r_y2 <= uy;
                        r_c2 <= ucode;
                    end
                    r_step  <= r_step + 1'b1;
                    r_state <= S_CHECK;
                end
                S_DONE: begin
                    if (i_pop) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[design/line_segment_window_clipper.sv]
// Cohen-Sutherland line clipper. Each item is one segment with two signed
// endpoints; the block returns exactly one result item per segment, giving
// whether it is visible inside the window and both endpoints as they stand
// when clipping stops (rejected segments report their endpoints too). The
// window is set through the configuration port; the user must write it only
// while the block is idle, and the block itself does not enforce this. A front
// stage classifies incoming endpoints and hands them to a two-entry queue, so
// new items are taken while the clip engine is busy or its result waits to be
// popped. The clip engine works one segment at a time, through at most
// MAX_CLIP_STEPS clip steps; a step forms the intersection point with the
// shared one-bit-per-cycle divider, which it skips when the run along the
// crossed axis is zero.
module line_segment_window_clipper #(
    parameter int COORD_WIDTH    = lswc_pkg::COORD_WIDTH_DEF,
    parameter int MAX_CLIP_STEPS = lswc_pkg::MAX_CLIP_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Segment input, queue style.
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    // Result output, queue style.
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_visible,
    output logic signed [COORD_WIDTH-1:0] o_clipped_start_x,
    output logic signed [COORD_WIDTH-1:0] o_clipped_start_y,
    output logic signed [COORD_WIDTH-1:0] o_clipped_end_x,
    output logic signed [COORD_WIDTH-1:0] o_clipped_end_y,
    // Window register writes.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data
);
    localparam int IW = 4 * COORD_WIDTH + 8;

    // Window registers; reset values give the default 50..100 square.
    logic signed [COORD_WIDTH-1:0] r_left, r_right, r_bottom, r_top;

    logic          q_push, q_full, q_pop, q_empty;
    logic [IW-1:0] q_wdata, q_rdata;

    // Register writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= COORD_WIDTH'(50);
            r_right  <= COORD_WIDTH'(100);
            r_bottom <= COORD_WIDTH'(50);
            r_top    <= COORD_WIDTH'(100);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lswc_pkg::REG_LEFT:   r_left   <= i_cfg_data;
                lswc_pkg::REG_RIGHT:  r_right  <= i_cfg_data;
                lswc_pkg::REG_BOTTOM: r_bottom <= i_cfg_data;
                lswc_pkg::REG_TOP:    r_top    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lswc_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_start_x(i_start_x),
        .i_start_y(i_start_y),
        .i_end_x  (i_end_x),
        .i_end_y  (i_end_y),
        .i_left   (r_left),
        .i_right  (r_right),
        .i_bottom (r_bottom),
        .i_top    (r_top),
        .o_q_push (q_push),
        .o_q_data (q_wdata),
        .i_q_full (q_full)
    );

    lswc_fifo #(
        .WIDTH(IW),
        .DEPTH(lswc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_data (q_rdata),
        .o_empty(q_empty)
    );

    lswc_back #(
        .COORD_WIDTH   (COORD_WIDTH),
        .MAX_CLIP_STEPS(MAX_CLIP_STEPS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_data (q_rdata),
        .i_q_empty(q_empty),
        .o_q_pop  (q_pop),
        .i_left   (r_left),
        .i_right  (r_right),
        .i_bottom (r_bottom),
        .i_top    (r_top),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_visible(o_visible),
        .o_x1     (o_clipped_start_x),
        .o_y1     (o_clipped_start_y),
        .o_x2     (o_clipped_end_x),
        .o_y2     (o_clipped_end_y)
    );

endmodule
